// ===== rtl/circular_linked_queue_manager_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circular linked queue manager
// Wrap concurrent checks so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_QUEUE_MANAGER_MACROS_SVH
`define CIRCULAR_LINKED_QUEUE_MANAGER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, held off while reset is asserted.
`define CLQM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication, held off while reset is asserted.
`define CLQM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define CLQM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CLQM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/clqm_pkg.sv =====
// ----------------------------------------------------------------------------
// clqm_pkg
// Word types, codes and the control store of the queue manager sequencer.
// ----------------------------------------------------------------------------
package clqm_pkg;

    // Operation codes; the unused code behaves as a size query.
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SIZE   = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_LINKED    = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] queue_id;
        logic [5:0] node_id;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] removed_node;
        logic [6:0] queue_length;
    } t_out;

    // Datapath action selected by one control word.
    typedef enum logic [3:0] {
        A_NONE   = 4'd0,
        A_LOAD   = 4'd1,
        A_REDUCE = 4'd2,
        A_FETCH  = 4'd3,
        A_DISP   = 4'd4,
        A_APP1   = 4'd5,
        A_APP2   = 4'd6,
        A_WALK1  = 4'd7,
        A_WALK2  = 4'd8,
        A_RM     = 4'd9,
        A_RESULT = 4'd10,
        A_EMIT   = 4'd11,
        A_CLEAR  = 4'd12
    } t_act;

    // Sequencing: next step, jump, jump if, wait here until, op dispatch.
    typedef enum logic [2:0] {
        J_NEXT = 3'd0,
        J_GOTO = 3'd1,
        J_IF   = 3'd2,
        J_WAIT = 3'd3,
        J_DISP = 3'd4
    } t_jmp;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_ACCEPT   = 3'd1,
        C_INRANGE  = 3'd2,
        C_HIT      = 3'd3,
        C_MORE     = 3'd4,
        C_OUT_FREE = 3'd5,
        C_CLR_LAST = 3'd6
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_REDUCE = 4'd1;
    localparam t_step S_FETCH  = 4'd2;
    localparam t_step S_DISP   = 4'd3;
    localparam t_step S_APP1   = 4'd4;
    localparam t_step S_APP2   = 4'd5;
    localparam t_step S_WALK1  = 4'd6;
    localparam t_step S_WALK2  = 4'd7;
    localparam t_step S_NOTIN  = 4'd8;
    localparam t_step S_RM     = 4'd9;
    localparam t_step S_REFUSE = 4'd10;
    localparam t_step S_EMPTY  = 4'd11;
    localparam t_step S_SIZE   = 4'd12;
    localparam t_step S_EMIT   = 4'd13;
    localparam t_step S_CLEAR  = 4'd14;

    typedef struct packed {
        t_act    act;
        t_jmp    jmp;
        t_cond   cond;
        t_step   target;
        t_status stat;
    } t_cw;

    // Flags the sequencer branches on.
    typedef struct packed {
        logic       accept;
        logic       in_range;
        logic       hit;
        logic       more;
        logic       out_free;
        logic       clr_last;
        logic [1:0] op;
        logic       hv;
        logic       linked;
    } t_flags;

    // Control store.
    function automatic t_cw ucode(input t_step s);
        t_cw cw;
        cw = '{act: A_NONE, jmp: J_GOTO, cond: C_NONE, target: S_IDLE, stat: STAT_OK};
        case (s)
            S_IDLE:   cw = '{act: A_LOAD,   jmp: J_WAIT, cond: C_ACCEPT,
                             target: S_REDUCE, stat: STAT_OK};
            S_REDUCE: cw = '{act: A_REDUCE, jmp: J_WAIT, cond: C_INRANGE,
                             target: S_FETCH, stat: STAT_OK};
            S_FETCH:  cw = '{act: A_FETCH,  jmp: J_NEXT, cond: C_NONE,
                             target: S_IDLE, stat: STAT_OK};
            S_DISP:   cw = '{act: A_DISP,   jmp: J_DISP, cond: C_NONE,
                             target: S_IDLE, stat: STAT_OK};
            S_APP1:   cw = '{act: A_APP1,   jmp: J_NEXT, cond: C_NONE,
                             target: S_IDLE, stat: STAT_OK};
            S_APP2:   cw = '{act: A_APP2,   jmp: J_GOTO, cond: C_NONE,
                             target: S_EMIT, stat: STAT_OK};
            S_WALK1:  cw = '{act: A_WALK1,  jmp: J_IF,   cond: C_HIT,
                             target: S_RM, stat: STAT_OK};
            S_WALK2:  cw = '{act: A_WALK2,  jmp: J_IF,   cond: C_MORE,
                             target: S_WALK1, stat: STAT_OK};
            S_NOTIN:  cw = '{act: A_RESULT, jmp: J_GOTO, cond: C_NONE,
                             target: S_EMIT, stat: STAT_NOT_FOUND};
            S_RM:     cw = '{act: A_RM,     jmp: J_GOTO, cond: C_NONE,
                             target: S_EMIT, stat: STAT_OK};
            S_REFUSE: cw = '{act: A_RESULT, jmp: J_GOTO, cond: C_NONE,
                             target: S_EMIT, stat: STAT_LINKED};
            S_EMPTY:  cw = '{act: A_RESULT, jmp: J_GOTO, cond: C_NONE,
                             target: S_EMIT, stat: STAT_EMPTY};
            S_SIZE:   cw = '{act: A_RESULT, jmp: J_NEXT, cond: C_NONE,
                             target: S_IDLE, stat: STAT_OK};
            S_EMIT:   cw = '{act: A_EMIT,   jmp: J_WAIT, cond: C_OUT_FREE,
                             target: S_IDLE, stat: STAT_OK};
            S_CLEAR:  cw = '{act: A_CLEAR,  jmp: J_WAIT, cond: C_CLR_LAST,
                             target: S_IDLE, stat: STAT_OK};
            default:  cw = '{act: A_NONE,   jmp: J_GOTO, cond: C_NONE,
                             target: S_IDLE, stat: STAT_OK};
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/clqm_seq.sv =====
// ----------------------------------------------------------------------------
// clqm_seq
// Step counter and control store; emits one control word per cycle.
// ----------------------------------------------------------------------------
module clqm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clqm_pkg::t_flags  i_flags,
    output clqm_pkg::t_cw     o_cw
);

    clqm_pkg::t_step r_step;
    clqm_pkg::t_step n_step;
    clqm_pkg::t_step disp_step;
    clqm_pkg::t_cw   cw;
    logic            cond_true;

    assign cw   = clqm_pkg::ucode(r_step);
    assign o_cw = cw;

    always_comb begin
        case (cw.cond)
            clqm_pkg::C_ACCEPT:   cond_true = i_flags.accept;
            clqm_pkg::C_INRANGE:  cond_true = i_flags.in_range;
            clqm_pkg::C_HIT:      cond_true = i_flags.hit;
            clqm_pkg::C_MORE:     cond_true = i_flags.more;
            clqm_pkg::C_OUT_FREE: cond_true = i_flags.out_free;
            clqm_pkg::C_CLR_LAST: cond_true = i_flags.clr_last;
            default:              cond_true = 1'b0;
        endcase
    end

    // Branch on the operation and on what the fetch returned.
    always_comb begin
        if (i_flags.op == clqm_pkg::OP_APPEND) begin
            disp_step = i_flags.linked ? clqm_pkg::S_REFUSE : clqm_pkg::S_APP1;
        end else if (i_flags.op == clqm_pkg::OP_REMOVE) begin
            if (!i_flags.hv) begin
                disp_step = clqm_pkg::S_EMPTY;
            end else if (!i_flags.linked) begin
                disp_step = clqm_pkg::S_NOTIN;
            end else begin
                disp_step = clqm_pkg::S_WALK1;
            end
        end else begin
            disp_step = clqm_pkg::S_SIZE;
        end
    end

    always_comb begin
        case (cw.jmp)
            clqm_pkg::J_NEXT: n_step = r_step + 4'd1;
            clqm_pkg::J_GOTO: n_step = cw.target;
            clqm_pkg::J_IF:   n_step = cond_true ? cw.target : r_step + 4'd1;
            clqm_pkg::J_WAIT: n_step = cond_true ? cw.target : r_step;
            clqm_pkg::J_DISP: n_step = disp_step;
            default:          n_step = clqm_pkg::S_IDLE;
        endcase
    end

    // Reset starts in the clearing pass over the linked flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= clqm_pkg::S_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== rtl/circular_linked_queue_manager.sv =====
// ----------------------------------------------------------------------------
// circular_linked_queue_manager
// Circular doubly linked queues over a shared node pool, run by microcode.
// ----------------------------------------------------------------------------
// Throughput: one word in flight; the next is taken the cycle after a result loads.
// Reset: synchronous, active low; queues empty, then a clearing pass over the
//   linked flags runs before the first input word is taken.
// ----------------------------------------------------------------------------
`include "circular_linked_queue_manager_macros.svh"

module circular_linked_queue_manager #(
    parameter int NODES  = 64,
    parameter int QUEUES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  clqm_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clqm_pkg::t_out  o_out_data
);

    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [6:0]  QLIM = 7'(QUEUES);
    localparam logic [12:0] NLIM = 13'(NODES);

    // Link tables, linked flags and per-queue head/count store.
    logic [NW-1:0] m_next   [NODES];
    logic [NW-1:0] m_prev   [NODES];
    logic          m_linked [NODES];
    logic [NW-1:0] m_head   [QUEUES];
    logic [CW-1:0] m_cnt    [QUEUES];

    // Registered read data.
    logic [NW-1:0] r_next_rd;
    logic [NW-1:0] r_prev_rd;
    logic          r_lnk_rd;
    logic [NW-1:0] r_qhead_rd;
    logic [CW-1:0] r_qcnt_rd;

    // Control state.
    logic [QUEUES-1:0] r_hv_bits;
    logic [NW-1:0]     r_clr;
    logic              r_out_valid;
    clqm_pkg::t_out    r_out_data;

    // Working registers of the current word.
    logic [1:0]    r_op;
    logic [1:0]    r_q;
    logic [5:0]    r_n;
    logic          r_hv;
    logic [NW-1:0] r_head;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_p;
    logic [CW-1:0] r_i;
    logic [NW-1:0] r_t;
    logic [1:0]    r_status;
    logic [5:0]    r_removed;
    logic [6:0]    r_len;

    clqm_pkg::t_cw    cw;
    clqm_pkg::t_flags flags;

    logic [NW-1:0] ni;
    logic [QW-1:0] qi;
    logic          accept;
    logic          out_free;
    logic          emit_load;
    logic          sole;
    logic [NW-1:0] app_tail;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;

    // Write and read ports.
    logic          nl_we;
    logic [NW-1:0] nl_wa;
    logic [NW-1:0] nl_wd;
    logic          pl_we;
    logic [NW-1:0] pl_wa;
    logic [NW-1:0] pl_wd;
    logic [NW-1:0] pl_ra;
    logic          ln_we;
    logic [NW-1:0] ln_wa;
    logic          ln_wd;
    logic          qs_we;
    logic [NW-1:0] qs_head_wd;
    logic [CW-1:0] qs_cnt_wd;
    logic          hv_set;
    logic          hv_clr;

    assign ni = NW'(r_n);
    assign qi = QW'(r_q);

    assign o_in_ready = (cw.act == clqm_pkg::A_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign emit_load  = (cw.act == clqm_pkg::A_EMIT) && out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Sole node: its successor is itself.
    assign sole     = (r_next_rd == ni);
    // Tail of a non-empty queue is the head's predecessor; an empty queue
    // closes the ring on the new node itself.
    assign app_tail = r_hv ? r_prev_rd : ni;
    assign cnt_inc  = r_cnt + CW'(1);
    assign cnt_dec  = r_cnt - CW'(1);

    assign flags.accept   = accept;
    assign flags.in_range = ({5'b0, r_q} < QLIM) && ({7'b0, r_n} < NLIM);
    assign flags.hit      = (r_p == ni);
    assign flags.more     = (r_i != r_cnt);
    assign flags.out_free = out_free;
    assign flags.clr_last = (r_clr == NW'(NODES - 1));
    assign flags.op       = r_op;
    assign flags.hv       = r_hv;
    assign flags.linked   = r_lnk_rd;

    clqm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    // Memory write ports, steered by the current action.
    always_comb begin
        nl_we      = 1'b0;
        nl_wa      = ni;
        nl_wd      = r_head;
        pl_we      = 1'b0;
        pl_wa      = ni;
        pl_wd      = app_tail;
        ln_we      = 1'b0;
        ln_wa      = ni;
        ln_wd      = 1'b0;
        qs_we      = 1'b0;
        qs_head_wd = r_head;
        qs_cnt_wd  = cnt_inc;
        hv_set     = 1'b0;
        hv_clr     = 1'b0;
        case (cw.act)
            clqm_pkg::A_APP1: begin
                // Point the new node at head and tail.
                nl_we = 1'b1;
                pl_we = 1'b1;
            end
            clqm_pkg::A_APP2: begin
                // Splice it in between tail and head; bump the count.
                nl_we  = 1'b1;
                nl_wa  = r_t;
                nl_wd  = ni;
                pl_we  = 1'b1;
                pl_wa  = r_head;
                pl_wd  = ni;
                ln_we  = 1'b1;
                ln_wd  = 1'b1;
                qs_we  = 1'b1;
                hv_set = 1'b1;
            end
            clqm_pkg::A_RM: begin
                ln_we = 1'b1;
                if (sole) begin
                    hv_clr = 1'b1;
                end else begin
                    // Bridge the neighbors; pass the head role on if needed.
                    pl_we      = 1'b1;
                    pl_wa      = r_next_rd;
                    pl_wd      = r_prev_rd;
                    nl_we      = 1'b1;
                    nl_wa      = r_prev_rd;
                    nl_wd      = r_next_rd;
                    qs_we      = 1'b1;
                    qs_head_wd = (r_head == ni) ? r_next_rd : r_head;
                    qs_cnt_wd  = cnt_dec;
                end
            end
            clqm_pkg::A_CLEAR: begin
                ln_we = 1'b1;
                ln_wa = r_clr;
            end
            default: begin
            end
        endcase
    end

    // Predecessor read: head at dispatch (for append), the node otherwise.
    assign pl_ra = (cw.act == clqm_pkg::A_DISP) ? r_qhead_rd : ni;

    always_ff @(posedge i_clk) begin
        if (nl_we) begin
            m_next[nl_wa] <= nl_wd;
        end
        r_next_rd <= m_next[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            m_prev[pl_wa] <= pl_wd;
        end
        r_prev_rd <= m_prev[pl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) begin
            m_linked[ln_wa] <= ln_wd;
        end
        r_lnk_rd <= m_linked[ni];
    end

    always_ff @(posedge i_clk) begin
        if (qs_we) begin
            m_head[qi] <= qs_head_wd;
            m_cnt[qi]  <= qs_cnt_wd;
        end
        r_qhead_rd <= m_head[qi];
        r_qcnt_rd  <= m_cnt[qi];
    end

    // Control state: queue-valid flags, clear counter, output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_bits   <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (hv_set) begin
                r_hv_bits[qi] <= 1'b1;
            end else if (hv_clr) begin
                r_hv_bits[qi] <= 1'b0;
            end
            if (cw.act == clqm_pkg::A_CLEAR) begin
                r_clr <= r_clr + NW'(1);
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; each action updates its own few.
    always_ff @(posedge i_clk) begin
        case (cw.act)
            clqm_pkg::A_LOAD: begin
                if (accept) begin
                    r_op <= i_in_data.op;
                    r_q  <= i_in_data.queue_id;
                    r_n  <= i_in_data.node_id;
                end
            end
            clqm_pkg::A_REDUCE: begin
                // One modulo subtract per cycle on each index.
                if ({5'b0, r_q} >= QLIM) begin
                    r_q <= 2'({5'b0, r_q} - QLIM);
                end
                if ({7'b0, r_n} >= NLIM) begin
                    r_n <= 6'({7'b0, r_n} - NLIM);
                end
            end
            clqm_pkg::A_FETCH: begin
                r_hv <= r_hv_bits[qi];
            end
            clqm_pkg::A_DISP: begin
                // Empty queue: count zero, new node becomes head.
                r_head <= r_hv ? r_qhead_rd : ni;
                r_cnt  <= r_hv ? r_qcnt_rd : '0;
                r_p    <= r_qhead_rd;
                r_i    <= '0;
            end
            clqm_pkg::A_APP1: begin
                r_t <= app_tail;
            end
            clqm_pkg::A_APP2: begin
                r_status  <= clqm_pkg::STAT_OK;
                r_removed <= '0;
                r_len     <= 7'(cnt_inc);
            end
            clqm_pkg::A_WALK1: begin
                r_i <= r_i + CW'(1);
            end
            clqm_pkg::A_WALK2: begin
                r_p <= r_next_rd;
            end
            clqm_pkg::A_RM: begin
                r_status  <= clqm_pkg::STAT_OK;
                r_removed <= r_n;
                r_len     <= sole ? 7'd0 : 7'(cnt_dec);
            end
            clqm_pkg::A_RESULT: begin
                r_status  <= cw.stat;
                r_removed <= '0;
                r_len     <= 7'(r_cnt);
            end
            clqm_pkg::A_EMIT: begin
                if (out_free) begin
                    r_out_data.status       <= r_status;
                    r_out_data.removed_node <= r_removed;
                    r_out_data.queue_length <= r_len;
                end
            end
            default: begin
            end
        endcase
    end

    // A node is only spliced in if it was free when fetched.
    `CLQM_ASSERT_IMP(a_app_free, i_clk, i_rst_n, cw.act == clqm_pkg::A_APP2, !r_lnk_rd)
    // The walk never visits more nodes than the queue holds.
    `CLQM_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, cw.act == clqm_pkg::A_WALK1, r_i < r_cnt)
    // Unlink only happens on a non-empty queue.
    `CLQM_ASSERT_IMP(a_rm_nonempty, i_clk, i_rst_n, cw.act == clqm_pkg::A_RM, r_hv && (r_cnt != '0))
    // An appended queue reads as non-empty afterwards.
    `CLQM_ASSERT_NXT(a_app_valid, i_clk, i_rst_n, hv_set, r_hv_bits[qi])

endmodule
